// File: rtl/mts_pkg.sv
// ---------------------------------------------------------------------------
// mts_pkg
// Shared codes and control types for the max-tracking stack.
// ---------------------------------------------------------------------------
package mts_pkg;

  // operation codes on in_mode
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic take;     // input transaction accepted this cycle
    logic rd_load;  // load top cache and output from memory read data
    logic out_pop;  // output transaction completes this cycle
  } mts_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic out_full;    // output register holds an untaken result
    logic needs_read;  // current input is a pop that uncovers a stored entry
  } mts_stat_t;

endpackage

// File: rtl/max_tracking_stack.sv
// ---------------------------------------------------------------------------
// max_tracking_stack
// LIFO stack of signed values that tracks the running maximum per entry.
//
// Input channel (in_valid/in_stall): in_mode selects push, pop, clear or
// read; in_value is the value pushed. Every input transaction yields exactly
// one output transaction (out_valid/out_stall) with the top value, the
// running maximum, the entry count, an empty flag and a status code.
// A push onto a full stack is dropped (status overflow); a pop on an empty
// stack is ignored (status underflow).
// Push, clear, read and a pop that empties the stack give their result in
// the cycle after acceptance: one transaction per cycle while out_stall is
// low. A pop that leaves entries behind reads the new top through the
// registered read port of the entry memory, then the output register; no
// input is accepted until that read result is loaded.
// Reset clears the entry count and the output valid flag; memory contents
// are not cleared and are never read before written.
// When the receiver stalls, the result holds in the output register and
// in_stall rises until the output slot frees up.
// ---------------------------------------------------------------------------
module max_tracking_stack
  import mts_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_top_value,
  output logic signed [DATA_WIDTH-1:0] out_top_max,
  output logic [CNT_W-1:0]             out_depth_used,
  output logic                         out_is_empty,
  output logic [1:0]                   out_status
);

  mts_cmd_t  cmd;
  mts_stat_t stat;

  // sequencing and handshake control
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and result datapath
  mts_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_top_value  (out_top_value),
    .out_top_max    (out_top_max),
    .out_depth_used (out_depth_used),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status)
  );

endmodule

// File: rtl/mts_ctrl.sv
// ---------------------------------------------------------------------------
// mts_ctrl
// Handshake and sequencing control: idle / wait-for-memory-read.
// ---------------------------------------------------------------------------
module mts_ctrl
  import mts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_stall,
  input  mts_stat_t stat,
  output mts_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_free;

  // output slot can take a new result this cycle
  assign out_free = !stat.out_full || !out_stall;

  // accept only in idle with room at the output
  assign in_stall = !((state_r == ST_IDLE) && out_free);

  always_comb begin
    state_nxt   = state_r;
    cmd.take    = 1'b0;
    cmd.rd_load = 1'b0;
    cmd.out_pop = stat.out_full && !out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && out_free) begin
          cmd.take = 1'b1;
          if (stat.needs_read) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd.rd_load = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/mts_dp.sv
// ---------------------------------------------------------------------------
// mts_dp
// Stack datapath: value/max memories, entry count, cached top and the
// output register.
// ---------------------------------------------------------------------------
module mts_dp
  import mts_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = $clog2(CAPACITY + 1),
  parameter int ADDR_W     = $clog2(CAPACITY)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  mts_cmd_t                     cmd,
  output mts_stat_t                    stat,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_top_value,
  output logic signed [DATA_WIDTH-1:0] out_top_max,
  output logic [CNT_W-1:0]             out_depth_used,
  output logic                         out_is_empty,
  output logic [1:0]                   out_status
);

  // storage
  logic signed [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic signed [DATA_WIDTH-1:0] max_mem [CAPACITY];
  logic signed [DATA_WIDTH-1:0] rd_val_r;
  logic signed [DATA_WIDTH-1:0] rd_max_r;

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic signed [DATA_WIDTH-1:0] top_val_r, top_val_nxt;
  logic signed [DATA_WIDTH-1:0] top_max_r, top_max_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_val_r, out_val_nxt;
  logic signed [DATA_WIDTH-1:0] out_max_r, out_max_nxt;
  logic [CNT_W-1:0]             out_cnt_r, out_cnt_nxt;
  logic [1:0]                   out_st_r, out_st_nxt;

  logic                         full;
  logic                         empty;
  logic signed [DATA_WIDTH-1:0] push_max;
  logic                         wr_en;
  logic                         rd_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [ADDR_W-1:0]            rd_addr;
  logic [CNT_W-1:0]             cnt_m2;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // running max: keep previous unless strictly greater
  assign push_max = (!empty && !(in_value > top_max_r)) ? top_max_r : in_value;

  assign stat.out_full   = out_valid_r;
  assign stat.needs_read = (in_mode == MODE_POP) && (count_r > CNT_W'(1));

  assign wr_en   = cmd.take && (in_mode == MODE_PUSH) && !full;
  assign wr_addr = count_r[ADDR_W-1:0];
  assign rd_en   = cmd.take && stat.needs_read;
  assign cnt_m2  = count_r - CNT_W'(2);
  assign rd_addr = cnt_m2[ADDR_W-1:0];

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[wr_addr] <= in_value;
      max_mem[wr_addr] <= push_max;
    end
    if (rd_en) begin
      rd_val_r <= val_mem[rd_addr];
      rd_max_r <= max_mem[rd_addr];
    end
  end

  // operation decode: new count, top cache and result
  always_comb begin
    count_nxt     = count_r;
    top_val_nxt   = top_val_r;
    top_max_nxt   = top_max_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_max_nxt   = out_max_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;

    if (cmd.out_pop) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.take) begin
      out_st_nxt  = ST_OK;
      out_val_nxt = empty ? '0 : top_val_r;
      out_max_nxt = empty ? '0 : top_max_r;
      out_cnt_nxt = count_r;
      out_valid_nxt = !stat.needs_read;
      case (in_mode)
        MODE_PUSH: begin
          if (full) begin
            out_st_nxt = ST_OVERFLOW;
          end else begin
            count_nxt   = count_r + CNT_W'(1);
            top_val_nxt = in_value;
            top_max_nxt = push_max;
            out_val_nxt = in_value;
            out_max_nxt = push_max;
            out_cnt_nxt = count_r + CNT_W'(1);
          end
        end
        MODE_POP: begin
          if (empty) begin
            out_st_nxt = ST_UNDERFLOW;
          end else begin
            count_nxt   = count_r - CNT_W'(1);
            out_cnt_nxt = count_r - CNT_W'(1);
            out_val_nxt = '0;
            out_max_nxt = '0;
          end
        end
        MODE_CLEAR: begin
          count_nxt   = '0;
          out_val_nxt = '0;
          out_max_nxt = '0;
          out_cnt_nxt = '0;
        end
        default: begin
          // read: nothing changes
        end
      endcase
    end

    // pop uncovered a stored entry: take it from the memory read
    if (cmd.rd_load) begin
      top_val_nxt   = rd_val_r;
      top_max_nxt   = rd_max_r;
      out_val_nxt   = rd_val_r;
      out_max_nxt   = rd_max_r;
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_max_r <= top_max_nxt;
    out_val_r <= out_val_nxt;
    out_max_r <= out_max_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_top_value  = out_val_r;
  assign out_top_max    = out_max_r;
  assign out_depth_used = out_cnt_r;
  assign out_is_empty   = (out_cnt_r == '0);
  assign out_status     = out_st_r;

endmodule
